@@ design/jlh_pkg.sv @@
package jlh_pkg;

  localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
  localparam logic [31:0] INIT_RESET = 32'h42424242;
  localparam logic [4:0] INDEX_BITS_RESET = 5'd10;
  localparam logic [4:0] INDEX_MAX_BITS = 5'd24;
  localparam int BLOCK_BYTES = 12;
  localparam int INDEX_W = 24;
  localparam logic [3:0] MIX_LAST = 4'd8;

  localparam logic [0:0] CFG_INITIAL_VALUE = 1'b0;
  localparam logic [0:0] CFG_INDEX_BITS = 1'b1;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  typedef struct packed {
    logic        blk;
    logic        fin;
    logic        first;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
    logic [31:0] init;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [31:0]        hash;
    logic [INDEX_W-1:0] index;
  } res_t;

  typedef enum logic [1:0] {
    MIX_IDLE,
    MIX_RUN,
    MIX_LEN
  } mix_state_t;

  function automatic words_t mix_step(words_t w, logic [3:0] step);
    words_t r;
    r = w;
    case (step)
      4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

@@ design/jlh_queue.sv @@
module jlh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ design/jlh_front.sv @@
module jlh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    key_byte,
  input  logic          byte_present,
  input  logic          last_byte,
  input  logic          push,
  output logic          full,
  input  logic [31:0]   init_value,
  output logic          req_push,
  output jlh_pkg::req_t req,
  input  logic          req_full
);
  import jlh_pkg::*;

  logic [7:0]  store [BLOCK_BYTES];
  logic [7:0]  bytes_new [BLOCK_BYTES];
  logic [7:0]  tail [BLOCK_BYTES];
  logic [3:0]  pos;
  logic [3:0]  pos_new;
  logic [3:0]  tail_n;
  logic [31:0] count;
  logic [31:0] key_init;
  logic        key_active;
  logic        sent;
  logic        accept;
  logic        blk_done;

  assign full     = req_full;
  assign accept   = push && !req_full;
  assign pos_new  = pos + {3'b000, byte_present};
  assign blk_done = (pos_new == 4'(BLOCK_BYTES));
  assign tail_n   = blk_done ? 4'd0 : pos_new;

  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      bytes_new[i] = (byte_present && pos == 4'(i)) ? key_byte : store[i];
      tail[i]      = (4'(i) < tail_n) ? bytes_new[i] : 8'h00;
    end
  end

  always_comb begin
    req.blk    = blk_done;
    req.fin    = last_byte;
    req.first  = !sent;
    req.init   = key_active ? key_init : init_value;
    req.length = count + {31'd0, byte_present};
    if (blk_done) begin
      req.add_a = {bytes_new[3], bytes_new[2], bytes_new[1], bytes_new[0]};
      req.add_b = {bytes_new[7], bytes_new[6], bytes_new[5], bytes_new[4]};
      req.add_c = {bytes_new[11], bytes_new[10], bytes_new[9], bytes_new[8]};
    end else begin
      // c low byte is left for the length
      req.add_a = {tail[3], tail[2], tail[1], tail[0]};
      req.add_b = {tail[7], tail[6], tail[5], tail[4]};
      req.add_c = {tail[10], tail[9], tail[8], 8'h00};
    end
  end

  assign req_push = accept && (blk_done || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      count      <= '0;
      key_active <= 1'b0;
      sent       <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        pos        <= '0;
        count      <= '0;
        key_active <= 1'b0;
        sent       <= 1'b0;
      end else if (byte_present) begin
        pos        <= blk_done ? 4'd0 : pos_new;
        count      <= count + 32'd1;
        key_active <= 1'b1;
        sent       <= sent || blk_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!key_active) begin
      key_init <= init_value;
    end
    if (accept) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        store[i] <= bytes_new[i];
      end
    end
  end

endmodule

@@ design/jlh_mixer.sv @@
module jlh_mixer (
  input  logic          clk,
  input  logic          rst,
  input  jlh_pkg::req_t req,
  input  logic          req_empty,
  output logic          req_pop,
  input  logic [4:0]    index_bits,
  output logic          out_push,
  output jlh_pkg::res_t out_res,
  input  logic          out_full
);
  import jlh_pkg::*;

  mix_state_t        state;
  mix_state_t        state_next;
  words_t            w;
  words_t            stepped;
  words_t            base;
  logic [3:0]        step;
  logic              fin_r;
  logic              len_pend;
  logic [31:0]       length_r;
  logic              start;
  logic              last_step;
  logic [4:0]        bits;
  logic [INDEX_W-1:0] mask;

  assign start     = (state == MIX_IDLE) && !req_empty && (!req.fin || !out_full);
  assign req_pop   = start;
  assign stepped   = mix_step(w, step);
  assign last_step = (step == MIX_LAST);
  assign bits      = (index_bits > INDEX_MAX_BITS) ? INDEX_MAX_BITS : index_bits;
  assign mask      = ~({INDEX_W{1'b1}} << bits);

  always_comb begin
    if (req.first) begin
      base.a = GOLDEN_WORD;
      base.b = GOLDEN_WORD;
      base.c = req.init;
    end else begin
      base = w;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MIX_IDLE: begin
        if (start) begin
          state_next = MIX_RUN;
        end
      end
      MIX_RUN: begin
        if (last_step) begin
          state_next = len_pend ? MIX_LEN : MIX_IDLE;
        end
      end
      MIX_LEN: state_next = MIX_RUN;
      default: state_next = MIX_IDLE;
    endcase
  end

  always_comb begin
    out_push      = (state == MIX_RUN) && last_step && !len_pend && fin_r;
    out_res.hash  = stepped.c;
    out_res.index = stepped.c[INDEX_W-1:0] & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= MIX_IDLE;
      fin_r    <= 1'b0;
      len_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        fin_r    <= req.fin;
        len_pend <= req.blk && req.fin;
      end else if (state == MIX_LEN) begin
        len_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MIX_IDLE: begin
        if (start) begin
          w.a      <= base.a + req.add_a;
          w.b      <= base.b + req.add_b;
          w.c      <= base.c + req.add_c + ((req.fin && !req.blk) ? req.length : 32'd0);
          length_r <= req.length;
          step     <= '0;
        end
      end
      MIX_RUN: begin
        w    <= stepped;
        step <= 4'(step + 4'd1);
      end
      MIX_LEN: begin
        w.c  <= w.c + length_r;
        step <= '0;
      end
      default: step <= '0;
    endcase
  end

`ifndef SYNTH
  a_out_room: assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("result written while result queue full");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == MIX_RUN) |-> (step <= MIX_LAST))
    else $error("mix step out of range");
  a_len_fin: assert property (@(posedge clk) disable iff (rst) len_pend |-> fin_r)
    else $error("length pending on a block-only request");
  a_pop_run: assert property (@(posedge clk) disable iff (rst) req_pop |=> (state == MIX_RUN))
    else $error("request taken without starting a mix");
`endif

endmodule

@@ design/jenkins_lookup2_byte_hash_unit.sv @@
// lookup2 byte-stream hash with bucket index
// input queue side: drive key_byte, byte_present, last_byte with push; the request
//   is taken when push is high and full is low. bytes stream in key order, last_byte
//   ends the key; byte_present low with last_byte high ends an empty key, and
//   byte_present low with last_byte low is a no-op
// result queue side: hash_value and table_index are valid while empty is low and
//   are taken when pop is high
// config: cfg_we writes cfg_data to register cfg_index (0 initial_value,
//   1 index_bits); initial_value is sampled when a key takes its first byte
// the front accepts one byte per cycle while full is low and packs 12-byte
//   blocks; each block and each key end go through a REQ_DEPTH-entry queue to one
//   shared mix unit; a key end whose last byte also completes a block gets a
//   second mix pass that adds the length; long keys run at one byte per cycle
//   while full is low, and the rate of short keys is set by the mix unit
// a stalled result side fills the OUT_DEPTH-entry result queue, then the mix unit
//   and the request queue, and then full goes high
// reset: clears both queues and the key state; initial_value returns to
//   0x42424242 and index_bits to 10
module jenkins_lookup2_byte_hash_unit #(
  parameter int REQ_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  key_byte,
  input  logic        byte_present,
  input  logic        last_byte,
  input  logic        push,
  output logic        full,
  output logic [31:0] hash_value,
  output logic [23:0] table_index,
  output logic        empty,
  input  logic        pop
);
  import jlh_pkg::*;

  logic [31:0] initial_value;
  logic [4:0]  index_bits;
  logic [31:0] init_eff;
  logic        req_push;
  logic        req_full;
  logic        req_pop;
  logic        req_empty;
  req_t        req_in;
  req_t        req_out;
  logic [$bits(req_t)-1:0] req_rdata;
  logic        out_push;
  logic        out_full;
  res_t        res_in;
  res_t        res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= INIT_RESET;
      index_bits    <= INDEX_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_VALUE: initial_value <= cfg_data;
        CFG_INDEX_BITS:    index_bits <= cfg_data[4:0];
        default:           index_bits <= index_bits;
      endcase
    end
  end

  assign init_eff = (cfg_we && cfg_index == CFG_INITIAL_VALUE) ? cfg_data : initial_value;

  jlh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .key_byte     (key_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .push         (push),
    .full         (full),
    .init_value   (init_eff),
    .req_push     (req_push),
    .req          (req_in),
    .req_full     (req_full)
  );

  jlh_queue #(
    .WIDTH ($bits(req_t)),
    .DEPTH (REQ_DEPTH)
  ) u_req_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (req_push),
    .wdata (req_in),
    .full  (req_full),
    .pop   (req_pop),
    .rdata (req_rdata),
    .empty (req_empty)
  );

  assign req_out = req_t'(req_rdata);

  jlh_mixer u_mixer (
    .clk        (clk),
    .rst        (rst),
    .req        (req_out),
    .req_empty  (req_empty),
    .req_pop    (req_pop),
    .index_bits (index_bits),
    .out_push   (out_push),
    .out_res    (res_in),
    .out_full   (out_full)
  );

  jlh_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out     = res_t'(res_rdata);
  assign hash_value  = res_out.hash;
  assign table_index = res_out.index;

endmodule
